// ----- design/nrcm_pkg.sv -----
// shared types, constants and codes for the nearest rectangle coordinate mapper
`default_nettype none
package nrcm_pkg;

	localparam int MAX_ROWS  = 16;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COUNT_W   = 5;
	localparam int COORD_W   = 24;
	localparam int EXT_W     = 23;
	localparam int SCALE_W   = 16;
	localparam int DIV_W     = 37;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [1:0] ACT_WR_PRIM = 2'd0;
	localparam logic [1:0] ACT_WR_SEC  = 2'd1;
	localparam logic [1:0] ACT_TO_SEC  = 2'd2;
	localparam logic [1:0] ACT_TO_PRIM = 2'd3;

	localparam logic CFG_MONITOR_COUNT = 1'b0;
	localparam logic CFG_FORCE_ZERO    = 1'b1;

	typedef struct packed {
		logic [1:0]                action;
		logic [3:0]                entry_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic [EXT_W-1:0]          extent_w;
		logic [EXT_W-1:0]          extent_h;
		logic [SCALE_W-1:0]        scale_value;
		logic                      use_preferred;
	} in_item_t;

	typedef struct packed {
		logic                      found;
		logic [3:0]                chosen_index;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic             fzs;
		logic             wr_prim;
		logic             wr_sec;
		logic             cap;
		logic             rd_en;
		logic             rd_chosen;
		logic [ROW_W-1:0] row;
		logic             gap;
		logic             sq;
		logic             cmp;
		logic             first;
		logic             set_chosen;
		logic             pick_best;
		logic             off;
		logic             mul;
		logic             div_start;
		logic             fin;
		logic             fin_nf;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

// ----- design/nrcm_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module nrcm_div (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  [nrcm_pkg::DIV_W-1:0]          dividend,
	input  wire  [nrcm_pkg::SCALE_W-1:0]        divisor,
	output logic [nrcm_pkg::DIV_W-1:0]          quotient,
	output logic                                done
);
	logic [nrcm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic [nrcm_pkg::SCALE_W-1:0]   rem_q;
	logic [nrcm_pkg::DIV_W-1:0]     quo_q;
	logic [nrcm_pkg::SCALE_W-1:0]   dsr_q;
	logic                           done_q;
	logic [nrcm_pkg::SCALE_W:0]     rem_sh;
	logic [nrcm_pkg::SCALE_W:0]     trial;

	always_comb begin
		rem_sh = {rem_q, quo_q[nrcm_pkg::DIV_W-1]};
		trial  = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == nrcm_pkg::DIV_CNT_W'(nrcm_pkg::DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!trial[nrcm_pkg::SCALE_W]) begin
				rem_q <= trial[nrcm_pkg::SCALE_W-1:0];
				quo_q <= {quo_q[nrcm_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[nrcm_pkg::SCALE_W-1:0];
				quo_q <= {quo_q[nrcm_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// ----- design/nrcm_dp.sv -----
// datapath: row table, distance stages, best-row tracking, offset scaling
`default_nettype none
module nrcm_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  nrcm_pkg::in_item_t   item,
	input  nrcm_pkg::cmd_t       cmd,
	output nrcm_pkg::sts_t       sts,
	output logic                 done,
	output nrcm_pkg::out_item_t  result
);
	typedef struct packed {
		logic signed [23:0] ox;
		logic signed [23:0] oy;
		logic [22:0]        w;
		logic [22:0]        h;
	} prim_row_t;

	typedef struct packed {
		logic signed [23:0] ox;
		logic signed [23:0] oy;
		logic [22:0]        w;
		logic [22:0]        h;
		logic [15:0]        scale;
	} sec_row_t;

	prim_row_t prim_mem [nrcm_pkg::MAX_ROWS];
	sec_row_t  sec_mem  [nrcm_pkg::MAX_ROWS];
	prim_row_t prim_rd_q;
	sec_row_t  sec_rd_q;

	logic signed [23:0] px_q, py_q;
	logic               to_sec_q;
	logic [nrcm_pkg::ROW_W-1:0] rd_addr;

	// distance stages
	logic [25:0] gx_s1, gy_s1;
	logic [26:0] cx_s1, cy_s1;
	logic        in_s1;
	logic [52:0] d_s2;
	logic [54:0] c_s2;
	logic        in_s2;

	logic        have_in_q;
	logic [52:0] din_q, dany_q;
	logic [54:0] cin_q, cany_q;
	logic [nrcm_pkg::ROW_W-1:0] best_in_q, best_any_q, chosen_q;

	// mapping
	logic signed [24:0] offx_q, offy_q;
	logic signed [23:0] tx_q, ty_q;
	logic [15:0]        scale_q;
	logic signed [41:0] prodx_q, prody_q;
	logic [36:0]        qx, qy;
	logic               dx_done, dy_done;

	logic               done_q;
	nrcm_pkg::out_item_t res_q;

	// right after a search the best row goes straight to the read port
	assign rd_addr = !cmd.rd_chosen ? cmd.row :
		(cmd.pick_best ? (have_in_q ? best_in_q : best_any_q) : chosen_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_prim)
			prim_mem[item.entry_index] <= '{item.coord_x, item.coord_y,
				item.extent_w, item.extent_h};
		if (cmd.wr_sec)
			sec_mem[item.entry_index] <= '{item.coord_x, item.coord_y,
				item.extent_w, item.extent_h, item.scale_value};
		if (cmd.rd_en) begin
			prim_rd_q <= prim_mem[rd_addr];
			sec_rd_q  <= sec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			px_q     <= item.coord_x;
			py_q     <= item.coord_y;
			to_sec_q <= (item.action == nrcm_pkg::ACT_TO_SEC);
		end
	end

	// rectangle of the row under test
	logic signed [26:0] ox27, oy27, w27, h27, p27x, p27y;
	logic signed [26:0] hix, hiy, lox_g, hix_g, loy_g, hiy_g, gapx, gapy;
	logic signed [27:0] cdx, cdy;
	logic [22:0]        rw, rh;
	logic signed [23:0] rox, roy;

	always_comb begin
		if (to_sec_q) begin
			rox = prim_rd_q.ox; roy = prim_rd_q.oy;
			rw  = prim_rd_q.w;  rh  = prim_rd_q.h;
		end else begin
			rox = sec_rd_q.ox; roy = sec_rd_q.oy;
			rw  = cmd.fzs ? sec_rd_q.w : prim_rd_q.w;
			rh  = cmd.fzs ? sec_rd_q.h : prim_rd_q.h;
		end
		ox27 = {{3{rox[23]}}, rox};
		oy27 = {{3{roy[23]}}, roy};
		w27  = {4'b0, rw};
		h27  = {4'b0, rh};
		p27x = {{3{px_q[23]}}, px_q};
		p27y = {{3{py_q[23]}}, py_q};
		hix  = ox27 + w27 - 27'sd256;
		hiy  = oy27 + h27 - 27'sd256;
		lox_g = ox27 - p27x;
		hix_g = p27x - hix;
		loy_g = oy27 - p27y;
		hiy_g = p27y - hiy;
		gapx = 27'sd0;
		if (lox_g > gapx) gapx = lox_g;
		if (hix_g > gapx) gapx = hix_g;
		gapy = 27'sd0;
		if (loy_g > gapy) gapy = loy_g;
		if (hiy_g > gapy) gapy = hiy_g;
		cdx = {p27x, 1'b0} - ({ox27, 1'b0} + {1'b0, w27});
		cdy = {p27y, 1'b0} - ({oy27, 1'b0} + {1'b0, h27});
	end

	always_ff @(posedge clk) begin
		if (cmd.gap) begin
			gx_s1 <= gapx[25:0];
			gy_s1 <= gapy[25:0];
			cx_s1 <= cdx[27] ? 27'(-cdx) : cdx[26:0];
			cy_s1 <= cdy[27] ? 27'(-cdy) : cdy[26:0];
			in_s1 <= (p27x >= ox27) && (p27x < ox27 + w27) &&
				(p27y >= oy27) && (p27y < oy27 + h27);
		end
		if (cmd.sq) begin
			d_s2  <= 53'(gx_s1 * gx_s1) + 53'(gy_s1 * gy_s1);
			c_s2  <= 55'(cx_s1 * cx_s1) + 55'(cy_s1 * cy_s1);
			in_s2 <= in_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_in_q <= 1'b0;
		end else if (cmd.cmp) begin
			if (in_s2 && (cmd.first || !have_in_q || d_s2 < din_q ||
					(d_s2 == din_q && c_s2 < cin_q)))
				have_in_q <= 1'b1;
			else if (cmd.first)
				have_in_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			if (in_s2 && (cmd.first || !have_in_q || d_s2 < din_q ||
					(d_s2 == din_q && c_s2 < cin_q))) begin
				din_q     <= d_s2;
				cin_q     <= c_s2;
				best_in_q <= cmd.row;
			end
			if (cmd.first || d_s2 < dany_q || (d_s2 == dany_q && c_s2 < cany_q)) begin
				dany_q     <= d_s2;
				cany_q     <= c_s2;
				best_any_q <= cmd.row;
			end
		end
		if (cmd.set_chosen)
			chosen_q <= cmd.row;
		else if (cmd.pick_best)
			chosen_q <= have_in_q ? best_in_q : best_any_q;
	end

	// offset from source origin, target origin latched alongside
	always_ff @(posedge clk) begin
		if (cmd.off) begin
			scale_q <= sec_rd_q.scale;
			if (to_sec_q) begin
				offx_q <= {px_q[23], px_q} - {prim_rd_q.ox[23], prim_rd_q.ox};
				offy_q <= {py_q[23], py_q} - {prim_rd_q.oy[23], prim_rd_q.oy};
				tx_q   <= sec_rd_q.ox;
				ty_q   <= sec_rd_q.oy;
			end else begin
				offx_q <= {px_q[23], px_q} - {sec_rd_q.ox[23], sec_rd_q.ox};
				offy_q <= {py_q[23], py_q} - {sec_rd_q.oy[23], sec_rd_q.oy};
				tx_q   <= prim_rd_q.ox;
				ty_q   <= prim_rd_q.oy;
			end
		end
		if (cmd.mul) begin
			prodx_q <= offx_q * $signed({1'b0, scale_q});
			prody_q <= offy_q * $signed({1'b0, scale_q});
		end
	end

	// divide operands: |off| * 4096 + scale / 2
	logic [24:0] absx, absy;
	logic [36:0] divx_n, divy_n;

	always_comb begin
		absx   = offx_q[24] ? 25'(-offx_q) : offx_q;
		absy   = offy_q[24] ? 25'(-offy_q) : offy_q;
		divx_n = {absx, 12'b0} + {22'b0, scale_q[15:1]};
		divy_n = {absy, 12'b0} + {22'b0, scale_q[15:1]};
	end

	nrcm_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (divx_n),
		.divisor  (scale_q),
		.quotient (qx),
		.done     (dx_done)
	);

	nrcm_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (divy_n),
		.divisor  (scale_q),
		.quotient (qy),
		.done     (dy_done)
	);

	assign sts.div_done = dx_done & dy_done;

	// final value, add target origin, saturate
	logic signed [41:0] rndx, rndy;
	logic signed [38:0] vx, vy, sx, sy;
	logic signed [23:0] satx, saty;

	always_comb begin
		rndx = prodx_q + 42'sd2048;
		rndy = prody_q + 42'sd2048;
		if (!cmd.fzs) begin
			vx = 39'(offx_q);
			vy = 39'(offy_q);
		end else if (to_sec_q) begin
			vx = 39'($signed(rndx[41:12]));
			vy = 39'($signed(rndy[41:12]));
		end else if (scale_q == '0) begin
			vx = offx_q[24] ? -39'sd33554432 : ((offx_q == '0) ? 39'sd0 : 39'sd33554432);
			vy = offy_q[24] ? -39'sd33554432 : ((offy_q == '0) ? 39'sd0 : 39'sd33554432);
		end else begin
			vx = offx_q[24] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
			vy = offy_q[24] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
		end
		sx = vx + 39'(tx_q);
		sy = vy + 39'(ty_q);
		if (sx > 39'sd8388607)       satx = 24'sh7FFFFF;
		else if (sx < -39'sd8388608) satx = 24'sh800000;
		else                         satx = sx[23:0];
		if (sy > 39'sd8388607)       saty = 24'sh7FFFFF;
		else if (sy < -39'sd8388608) saty = 24'sh800000;
		else                         saty = sy[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.fin | cmd.fin_nf;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin)
			res_q <= '{1'b1, 4'(chosen_q), satx, saty};
		else if (cmd.fin_nf)
			res_q <= '0;
	end

	assign done   = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

// ----- design/nrcm_ctrl.sv -----
// controller: configuration registers and the query sequencer
`default_nettype none
module nrcm_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  nrcm_pkg::in_item_t  item,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [4:0]          cfg_wdata,
	input  nrcm_pkg::sts_t      sts,
	output logic                busy,
	output nrcm_pkg::cmd_t      cmd
);
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ROW_RD  = 4'd1;
	localparam logic [3:0] ST_ROW_GAP = 4'd2;
	localparam logic [3:0] ST_ROW_SQ  = 4'd3;
	localparam logic [3:0] ST_ROW_CMP = 4'd4;
	localparam logic [3:0] ST_MAP_RD  = 4'd5;
	localparam logic [3:0] ST_MAP_OFF = 4'd6;
	localparam logic [3:0] ST_MAP_SCL = 4'd7;
	localparam logic [3:0] ST_MAP_DIV = 4'd8;
	localparam logic [3:0] ST_MAP_FIN = 4'd9;

	logic [3:0]                     state_q, state_n;
	logic [nrcm_pkg::COUNT_W-1:0]   mcount_q;
	logic                           fzs_q;
	logic [nrcm_pkg::ROW_W-1:0]     row_q, row_n;
	logic                           to_sec_q;
	logic [nrcm_pkg::COUNT_W-1:0]   count;
	logic                           accept, is_query;
	logic                           pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcount_q <= '0;
			fzs_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nrcm_pkg::CFG_MONITOR_COUNT: mcount_q <= cfg_wdata;
				nrcm_pkg::CFG_FORCE_ZERO:    fzs_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign count = (mcount_q > nrcm_pkg::COUNT_W'(nrcm_pkg::MAX_ROWS)) ?
		nrcm_pkg::COUNT_W'(nrcm_pkg::MAX_ROWS) : mcount_q;
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign is_query = item.action[1];

	always_comb begin
		cmd       = '0;
		cmd.fzs   = fzs_q;
		cmd.row   = row_q;
		state_n   = state_q;
		row_n     = row_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.wr_prim = (item.action == nrcm_pkg::ACT_WR_PRIM);
					cmd.wr_sec  = (item.action == nrcm_pkg::ACT_WR_SEC);
					cmd.cap     = is_query;
					if (is_query) begin
						if (item.use_preferred) begin
							if ({1'b0, item.entry_index} < count) begin
								cmd.row        = item.entry_index;
								cmd.set_chosen = 1'b1;
								state_n        = ST_MAP_RD;
							end else begin
								cmd.fin_nf = 1'b1;
							end
						end else if (count == '0) begin
							cmd.fin_nf = 1'b1;
						end else if (count == nrcm_pkg::COUNT_W'(1)) begin
							cmd.row        = '0;
							cmd.set_chosen = 1'b1;
							state_n        = ST_MAP_RD;
						end else begin
							row_n   = '0;
							state_n = ST_ROW_RD;
						end
					end
				end
			end
			ST_ROW_RD: begin
				cmd.rd_en = 1'b1;
				state_n   = ST_ROW_GAP;
			end
			ST_ROW_GAP: begin
				cmd.gap = 1'b1;
				state_n = ST_ROW_SQ;
			end
			ST_ROW_SQ: begin
				cmd.sq  = 1'b1;
				state_n = ST_ROW_CMP;
			end
			ST_ROW_CMP: begin
				cmd.cmp   = 1'b1;
				cmd.first = (row_q == '0);
				if ({1'b0, row_q} == count - 1'b1) begin
					state_n = ST_MAP_RD;
				end else begin
					row_n   = row_q + 1'b1;
					state_n = ST_ROW_RD;
				end
			end
			ST_MAP_RD: begin
				// after a search the best row is read and latched as chosen
				cmd.rd_en     = 1'b1;
				cmd.rd_chosen = 1'b1;
				cmd.pick_best = pick_q;
				state_n       = ST_MAP_OFF;
			end
			ST_MAP_OFF: begin
				cmd.off = 1'b1;
				state_n = fzs_q ? ST_MAP_SCL : ST_MAP_FIN;
			end
			ST_MAP_SCL: begin
				cmd.mul       = to_sec_q;
				cmd.div_start = !to_sec_q;
				state_n       = to_sec_q ? ST_MAP_FIN : ST_MAP_DIV;
			end
			ST_MAP_DIV: begin
				if (sts.div_done)
					state_n = ST_MAP_FIN;
			end
			ST_MAP_FIN: begin
				cmd.fin = 1'b1;
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// chosen row from the search is taken as the row read starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			to_sec_q <= 1'b0;
			pick_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			row_q   <= row_n;
			pick_q  <= (state_q == ST_ROW_CMP) && (state_n == ST_MAP_RD);
			if (accept && is_query)
				to_sec_q <= (item.action == nrcm_pkg::ACT_TO_SEC);
		end
	end
endmodule
`default_nettype wire

// ----- design/nearest_rect_coord_mapper_top.sv -----
// top level of the nearest rectangle coordinate mapper
`default_nettype none
// usage
// - item channel: drive item and raise start; the beat is taken at a clock edge where
//   start is high and busy is low
// - write items (primary or secondary row data) give no result and keep the block idle
// - query items give exactly one result beat: done is high for one cycle with result
// - the receiver cannot stall: result is valid only in the cycle done is high
// - configuration: cfg_we, cfg_index, cfg_wdata, written at once; only while idle
//   (user's rule, unchecked); index 0 is monitor_count, index 1 is force_zero_scaling
// steps of a query, from the accepting edge to the done cycle
// - no row usable: done follows in the next cycle, with an all-zero result
// - preferred row or one row in use: row read, offset, result
// - search over n rows: each row in the shared distance stages, then the mapping
// - scaling adds a multiply (forward map) or the bit-serial divider (backward map)
// throughput: one query at a time, busy stays high until the last cycle of a query
// that reads a row; the next item can be taken in the cycle done is high
// reset: arst_n clears the configuration and the sequencer; the row table is not
// cleared and must be written before use
module nearest_rect_coord_mapper_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  nrcm_pkg::in_item_t   item,
	output logic                 busy,
	output logic                 done,
	output nrcm_pkg::out_item_t  result,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire  [4:0]           cfg_wdata
);
	nrcm_pkg::cmd_t ctrl_cmd;
	nrcm_pkg::sts_t dp_sts;

	nrcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sts       (dp_sts),
		.busy      (busy),
		.cmd       (ctrl_cmd)
	);

	nrcm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (ctrl_cmd),
		.sts    (dp_sts),
		.done   (done),
		.result (result)
	);
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the nearest rectangle coordinate mapper
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import nrcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam longint SAT_HI = 8388607;
	localparam longint SAT_LO = -8388608;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_item_t item = '0;
	logic busy, done;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [4:0] cfg_wdata = '0;

	nearest_rect_coord_mapper_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor copy of the row table and the registers
	longint prim_x[MAX_ROWS], prim_y[MAX_ROWS], log_w[MAX_ROWS], log_h[MAX_ROWS];
	longint sec_x[MAX_ROWS], sec_y[MAX_ROWS], pix_w[MAX_ROWS], pix_h[MAX_ROWS];
	longint scale_of[MAX_ROWS];
	int rows_in_use = 0;
	bit scaling_on = 1'b0;

	in_item_t pending_beats[$];
	out_item_t mapped_points[$];
	int idle_pct = 0;
	int errors = 0;
	int queries_sent = 0, writes_sent = 0, results_seen = 0;
	int watchdog = 0;

	// snapshots taken mid-cycle so the edge sees settled values
	logic busy_s = 1'b1, done_s = 1'b0;
	out_item_t result_s;

	function automatic longint sat24(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint gap_of(longint p, longint lo, longint hi);
		longint g;
		g = 0;
		if (lo - p > g) g = lo - p;
		if (p - hi > g) g = p - hi;
		return g;
	endfunction

	function automatic longint unsigned squared(longint v);
		longint unsigned a;
		a = (v < 0) ? longint'(-v) : longint'(v);
		return a * a;
	endfunction

	// offset times scale, q.20 back to q16.8, halves up
	function automatic longint scale_up(longint off, longint s);
		return (off * s + 2048) >>> 12;
	endfunction

	// offset divided by scale, halves away from zero
	function automatic longint scale_down(longint off, longint s);
		longint unsigned a, q;
		if (s == 0) begin
			if (off > 0) return SAT_HI * 4;
			if (off < 0) return SAT_LO * 4;
			return 0;
		end
		a = longint'((off < 0) ? -off : off) * 4096;
		q = (a + s / 2) / s;
		return (off < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void store_row(in_item_t it);
		if (it.action == ACT_WR_PRIM) begin
			prim_x[it.entry_index] = longint'($signed(it.coord_x));
			prim_y[it.entry_index] = longint'($signed(it.coord_y));
			log_w[it.entry_index] = longint'(it.extent_w);
			log_h[it.entry_index] = longint'(it.extent_h);
		end else begin
			sec_x[it.entry_index] = longint'($signed(it.coord_x));
			sec_y[it.entry_index] = longint'($signed(it.coord_y));
			pix_w[it.entry_index] = longint'(it.extent_w);
			pix_h[it.entry_index] = longint'(it.extent_h);
			scale_of[it.entry_index] = longint'(it.scale_value);
		end
	endfunction

	function automatic out_item_t map_point(in_item_t it);
		out_item_t r;
		longint px, py, ox, oy, w, h, offx, offy, rx, ry;
		longint unsigned d, c, din, cin, dany, cany;
		bit to_sec, found, have_in, have_any, hit;
		int n, pick, best_in, best_any;
		px = longint'($signed(it.coord_x));
		py = longint'($signed(it.coord_y));
		to_sec = (it.action == ACT_TO_SEC);
		n = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
		found = 1'b0; pick = 0; rx = 0; ry = 0;
		have_in = 1'b0; have_any = 1'b0; best_in = 0; best_any = 0;
		din = 0; cin = 0; dany = 0; cany = 0;
		if (it.use_preferred) begin
			if (int'(it.entry_index) < n) begin
				found = 1'b1; pick = int'(it.entry_index);
			end
		end else if (n == 1) begin
			found = 1'b1;
		end else if (n > 1) begin
			for (int i = 0; i < n; i++) begin
				if (to_sec) begin
					ox = prim_x[i]; oy = prim_y[i]; w = log_w[i]; h = log_h[i];
				end else begin
					ox = sec_x[i]; oy = sec_y[i];
					w = scaling_on ? pix_w[i] : log_w[i];
					h = scaling_on ? pix_h[i] : log_h[i];
				end
				d = squared(gap_of(px, ox, ox + w - 256)) + squared(gap_of(py, oy, oy + h - 256));
				c = squared(2 * px - (2 * ox + w)) + squared(2 * py - (2 * oy + h));
				hit = px >= ox && px < ox + w && py >= oy && py < oy + h;
				if (hit && (!have_in || d < din || (d == din && c < cin))) begin
					have_in = 1'b1; best_in = i; din = d; cin = c;
				end
				if (!have_any || d < dany || (d == dany && c < cany)) begin
					have_any = 1'b1; best_any = i; dany = d; cany = c;
				end
			end
			found = 1'b1;
			pick = have_in ? best_in : best_any;
		end
		if (found) begin
			if (to_sec) begin
				offx = px - prim_x[pick]; offy = py - prim_y[pick];
				if (scaling_on) begin
					offx = scale_up(offx, scale_of[pick]);
					offy = scale_up(offy, scale_of[pick]);
				end
				rx = sat24(offx + sec_x[pick]); ry = sat24(offy + sec_y[pick]);
			end else begin
				offx = px - sec_x[pick]; offy = py - sec_y[pick];
				if (scaling_on) begin
					offx = scale_down(offx, scale_of[pick]);
					offy = scale_down(offy, scale_of[pick]);
				end
				rx = sat24(offx + prim_x[pick]); ry = sat24(offy + prim_y[pick]);
			end
		end
		r.found = found;
		r.chosen_index = found ? pick[3:0] : 4'd0;
		r.out_x = rx[23:0];
		r.out_y = ry[23:0];
		return r;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	always @(negedge clk) begin
		busy_s <= busy;
		done_s <= done;
		result_s <= result;
	end

	// driver: a beat is taken at an edge with start high and busy low
	always @(posedge clk) begin
		in_item_t nxt;
		bit took;
		took = start && !busy_s;
		if (took) begin
			if (item.action == ACT_WR_PRIM || item.action == ACT_WR_SEC) begin
				store_row(item);
				writes_sent++;
			end else begin
				mapped_points.push_back(map_point(item));
				queries_sent++;
			end
			void'(pending_beats.pop_front());
		end
		if (took || !start) begin
			if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = pending_beats[0];
				item <= nxt;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done cycle carries one result beat
	always @(posedge clk) begin
		out_item_t want;
		if (done_s) begin
			results_seen++;
			if (mapped_points.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = mapped_points.pop_front();
				if (result_s.found !== want.found)
					report($sformatf("found %0b want %0b", result_s.found, want.found));
				if (result_s.chosen_index !== want.chosen_index)
					report($sformatf("index %0d want %0d", result_s.chosen_index,
						want.chosen_index));
				if (result_s.out_x !== want.out_x)
					report($sformatf("out_x %h want %h", result_s.out_x, want.out_x));
				if (result_s.out_y !== want.out_y)
					report($sformatf("out_y %h want %h", result_s.out_y, want.out_y));
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy_s) || done_s || cfg_we || !arst_n) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [4:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MONITOR_COUNT) rows_in_use = int'(val);
		else scaling_on = val[0];
	endtask

	// wait until the block is idle and nothing is owed
	task automatic drain();
		while (pending_beats.size() != 0 || start || mapped_points.size() != 0 || busy_s)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_item_t row_write(logic [1:0] act, int row, bit wild);
		in_item_t it;
		it = '0;
		it.action = act;
		it.entry_index = row[3:0];
		if (wild) begin
			it.coord_x = 24'($urandom); it.coord_y = 24'($urandom);
			it.extent_w = 23'($urandom); it.extent_h = 23'($urandom);
		end else begin
			it.coord_x = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			it.coord_y = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			it.extent_w = 23'($urandom_range(256, 1 << 18));
			it.extent_h = 23'($urandom_range(256, 1 << 18));
		end
		it.scale_value = 16'($urandom_range(1, 65535));
		it.use_preferred = 1'($urandom);
		return it;
	endfunction

	function automatic in_item_t random_beat();
		in_item_t it;
		int pct, row;
		longint ox, oy, w, h;
		pct = $urandom_range(0, 99);
		row = $urandom_range(0, MAX_ROWS - 1);
		if (pct < 8) return row_write(ACT_WR_PRIM, row, $urandom_range(0, 7) == 0);
		if (pct < 16) return row_write(ACT_WR_SEC, row, $urandom_range(0, 7) == 0);
		it = '0;
		it.action = $urandom_range(0, 1) ? ACT_TO_SEC : ACT_TO_PRIM;
		it.entry_index = 4'($urandom);
		it.use_preferred = ($urandom_range(0, 3) == 0);
		it.extent_w = 23'($urandom); it.extent_h = 23'($urandom);
		it.scale_value = 16'($urandom);
		if (pct < 22) begin
			// noise: any point at all
			it.coord_x = 24'($urandom); it.coord_y = 24'($urandom);
		end else begin
			// point in or just around a known rectangle
			if (it.action == ACT_TO_SEC) begin
				ox = prim_x[row]; oy = prim_y[row]; w = log_w[row]; h = log_h[row];
			end else begin
				ox = sec_x[row]; oy = sec_y[row];
				w = scaling_on ? pix_w[row] : log_w[row];
				h = scaling_on ? pix_h[row] : log_h[row];
			end
			ox = ox + longint'($urandom_range(0, 1 << 16)) * w / 65536 - $urandom_range(0, 512);
			oy = oy + longint'($urandom_range(0, 1 << 16)) * h / 65536 - $urandom_range(0, 512);
			it.coord_x = 24'(sat24(ox));
			it.coord_y = 24'(sat24(oy));
		end
		return it;
	endfunction

	function automatic in_item_t query(logic [1:0] act, int row, bit pref, longint x, longint y);
		in_item_t it;
		it = '0;
		it.action = act;
		it.entry_index = row[3:0];
		it.use_preferred = pref;
		it.coord_x = x[23:0];
		it.coord_y = y[23:0];
		return it;
	endfunction

	int count_plan[6] = '{16, 0, 1, 31, 5, 16};
	int scale_plan[6] = '{1, 1, 0, 0, 1, 0};
	int idle_plan[3] = '{34, 55, 0};

	initial begin
		in_item_t w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill every row so no query reads an unwritten entry
		for (int r = 0; r < MAX_ROWS; r++) begin
			pending_beats.push_back(row_write(ACT_WR_PRIM, r, 1'b0));
			w = row_write(ACT_WR_SEC, r, 1'b0);
			if (r == 0) begin
				w.coord_x = 24'h800000; w.coord_y = 24'h7fffff;
				w.extent_w = 23'h7fffff; w.extent_h = 23'h7fffff;
				w.scale_value = 16'hffff;
			end
			if (r == 3) w.scale_value = 16'd0; // zero scale row
			if (r == 4) w.scale_value = 16'd1;
			pending_beats.push_back(w);
		end
		w = row_write(ACT_WR_PRIM, 1, 1'b0);
		w.coord_x = 24'h7fffff; w.coord_y = 24'h800000;
		w.extent_w = 23'h7fffff; w.extent_h = 23'd0;
		pending_beats.push_back(w);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_MONITOR_COUNT, count_plan[ph][4:0]);
			write_reg(CFG_FORCE_ZERO, scale_plan[ph][0]);
			idle_pct = idle_plan[ph % 3];
			if (ph == 0) begin
				// corner points, preferred rows, zero and unit scale, saturation
				pending_beats.push_back(query(ACT_TO_SEC, 0, 1, SAT_HI, SAT_HI));
				pending_beats.push_back(query(ACT_TO_SEC, 0, 1, SAT_LO, SAT_LO));
				pending_beats.push_back(query(ACT_TO_PRIM, 0, 1, SAT_HI, SAT_LO));
				pending_beats.push_back(query(ACT_TO_PRIM, 15, 1, SAT_LO, SAT_HI));
				pending_beats.push_back(query(ACT_TO_PRIM, 3, 1, sec_x[3] + 300, sec_y[3] - 300));
				pending_beats.push_back(query(ACT_TO_PRIM, 3, 1, sec_x[3], sec_y[3]));
				pending_beats.push_back(query(ACT_TO_PRIM, 4, 1, SAT_HI, SAT_LO));
				pending_beats.push_back(query(ACT_TO_SEC, 4, 1, prim_x[4] + 2048,
					prim_y[4] - 2048));
				pending_beats.push_back(query(ACT_TO_SEC, 2, 0, prim_x[2], prim_y[2]));
				pending_beats.push_back(query(ACT_TO_SEC, 2, 0, prim_x[2] + log_w[2] - 1,
					prim_y[2] + log_h[2] - 1));
				pending_beats.push_back(query(ACT_TO_SEC, 2, 0, prim_x[2] + log_w[2],
					prim_y[2] + log_h[2]));
				pending_beats.push_back(query(ACT_TO_SEC, 0, 0, SAT_HI, SAT_HI));
				pending_beats.push_back(query(ACT_TO_SEC, 0, 0, SAT_LO, SAT_LO));
				pending_beats.push_back(query(ACT_TO_PRIM, 0, 0, 0, 0));
				pending_beats.push_back(query(ACT_TO_PRIM, 0, 0, -1, -1));
			end
			for (int half = 0; half < 2; half++) begin
				repeat (30) pending_beats.push_back(random_beat());
				drain(); // sender holds off until every result is back
			end
		end

		$display("covered %0d queries and %0d row writes, %0d result beats checked",
			queries_sent, writes_sent, results_seen);
		$display("row counts 0, 1, 5, 16 and 31 with scaling on and off");
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/nrcm_pkg.sv
design/nrcm_div.sv
design/nrcm_dp.sv
design/nrcm_ctrl.sv
design/nearest_rect_coord_mapper_top.sv
tb/tb_top.sv
